/* src/tal_pkg.sv */
// Package for the turbidity averaging and linearization unit: widths, calibration table, classes.
`default_nettype none

package tal_pkg;

    // Field widths.
    localparam int SAMPLE_W = 12;
    localparam int SCALE_W  = 12;
    localparam int NTU_W    = 16;
    localparam int CLASS_W  = 3;
    localparam int MV_W     = 16;

    // Reference voltage in millivolts and the width of scale * VREF_MV.
    localparam int VREF_MV = 3300;
    localparam int K_W     = SCALE_W + $clog2(VREF_MV + 1);

    // The correction factor resets to 1.0 in Q4.8.
    localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd256;

    // Calibration table: voltage points in mV and turbidity in tenths of NTU.
    localparam int TABLE_POINTS = 8;
    localparam int CAL_W        = 13;
    localparam int OFF_W        = 10;
    localparam int DN_W         = 14;
    localparam int PROD_W       = OFF_W + DN_W;

    localparam logic [CAL_W-1:0] CAL_MV [TABLE_POINTS] = '{
        13'd4100, 13'd3800, 13'd3500, 13'd3000, 13'd2500, 13'd2000, 13'd1000, 13'd0
    };
    localparam logic [NTU_W-1:0] CAL_TENTHS [TABLE_POINTS] = '{
        16'd0, 16'd2000, 16'd5000, 16'd10000, 16'd20000, 16'd30000, 16'd38000, 16'd40000
    };

    localparam logic [NTU_W-1:0] TENTHS_CLEAR = 16'd0;
    localparam logic [NTU_W-1:0] TENTHS_MAX   = 16'd40000;

    // Quality classes.
    localparam logic [CLASS_W-1:0] CLASS_EXCELLENT = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_GOOD      = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_FAIR      = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_POOR      = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_VERY_POOR = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_EXTREME   = 3'd5;

    // Upper bounds of the classes, in tenths of NTU.
    localparam logic [NTU_W-1:0] BOUND_EXCELLENT = 16'd500;
    localparam logic [NTU_W-1:0] BOUND_GOOD      = 16'd2000;
    localparam logic [NTU_W-1:0] BOUND_FAIR      = 16'd10000;
    localparam logic [NTU_W-1:0] BOUND_POOR      = 16'd25000;
    localparam logic [NTU_W-1:0] BOUND_VERY_POOR = 16'd35000;

    function automatic logic [CLASS_W-1:0] classify(input logic [NTU_W-1:0] tenths);
        logic [CLASS_W-1:0] cls;
        if (tenths < BOUND_EXCELLENT) cls = CLASS_EXCELLENT;
        else if (tenths < BOUND_GOOD) cls = CLASS_GOOD;
        else if (tenths < BOUND_FAIR) cls = CLASS_FAIR;
        else if (tenths < BOUND_POOR) cls = CLASS_POOR;
        else if (tenths < BOUND_VERY_POOR) cls = CLASS_VERY_POOR;
        else cls = CLASS_EXTREME;
        return cls;
    endfunction

endpackage

`default_nettype wire

/* src/tal_sample_if.sv */
// Stream interface that carries one raw converter sample per transfer.
`default_nettype none

interface tal_sample_if;
    logic                           valid;
    logic                           ready;
    logic [tal_pkg::SAMPLE_W-1:0]   adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

/* src/tal_result_if.sv */
// Stream interface that carries one turbidity result per transfer.
`default_nettype none

interface tal_result_if;
    logic                           valid;
    logic                           ready;
    logic [tal_pkg::NTU_W-1:0]      ntu_tenths;
    logic [tal_pkg::CLASS_W-1:0]    quality_class;
    logic [tal_pkg::MV_W-1:0]       sensor_mv;

    modport source (output valid, output ntu_tenths, output quality_class, output sensor_mv,
                    input ready);
    modport sink   (input valid, input ntu_tenths, input quality_class, input sensor_mv,
                    output ready);
endinterface

`default_nettype wire

/* src/tal_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module tal_serial_mul #(
    parameter int A_W = 16,
    parameter int B_W = 24,
    parameter int P_W = 40
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [A_W-1:0] a,
    input  wire logic [B_W-1:0] b,
    output logic                done,
    output logic [P_W-1:0]      product
);

    localparam int CNT_W = $clog2(A_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [P_W-1:0]   b_reg, b_next;
    logic [P_W-1:0]   acc_reg, acc_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            cnt_next = CNT_W'(A_W);
            a_next   = a;
            b_next   = P_W'(b);
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            if (a_reg[0])
            begin
                acc_next = acc_reg + b_reg;
            end
            a_next    = a_reg >> 1;
            b_next    = b_reg << 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

/* src/tal_serial_div.sv */
// Restoring divider that produces one quotient bit per cycle, with an overflow flag.
`default_nettype none

module tal_serial_div #(
    parameter int N_W = 40,
    parameter int D_W = 24,
    parameter int Q_W = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic                done,
    output logic [Q_W-1:0]      quotient,
    output logic                overflow
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [N_W-1:0]   num_reg, num_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, num_reg[N_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        cnt_next  = cnt_reg;
        done_next = 1'b0;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            cnt_next = CNT_W'(N_W);
            num_next = num;
            den_next = den;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            // A quotient bit that leaves the top of the register marks overflow.
            rem_next  = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[Q_W-2:0], fits};
            ovf_next  = ovf_reg | quo_reg[Q_W-1];
            num_next  = num_reg << 1;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

`default_nettype wire

/* src/turbidity_average_linearize_unit.sv */
// Top level of the turbidity averaging and linearization unit.
// Samples that do not close a group are taken one per cycle and only add into the sum.
// The sample that closes a group starts a result that is worked out by the bit-serial
// multiplier and the bit-serial divider, which runs twice unless the voltage is clamped;
// no sample is taken until the result has been loaded into the output register.
// Reset clears the sum, the count and the pending result, and sets the scale to 1.0.
`default_nettype none

module turbidity_average_linearize_unit #(
    parameter int SAMPLES  = 10
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [tal_pkg::SCALE_W-1:0]    cfg_write_data,
    tal_sample_if.sink                          sample,
    tal_result_if.source                        result
);

    // The sum of a full group of 12-bit samples sets the accumulator width. The numerator
    // of the millivolt conversion is sum * scale * 3300, and the divisor is the constant
    // SAMPLES * ADC_MAX * 256, where ADC_MAX is the full scale of the sample field.
    localparam int          K_W     = tal_pkg::K_W;
    localparam int          MV_W    = tal_pkg::MV_W;
    localparam int          NTU_W   = tal_pkg::NTU_W;
    localparam int          PROD_W  = tal_pkg::PROD_W;
    localparam int          OFF_W   = tal_pkg::OFF_W;
    localparam int          DN_W    = tal_pkg::DN_W;
    localparam int          CAL_W   = tal_pkg::CAL_W;
    localparam logic [63:0] SUM_MAX = 64'(SAMPLES) * ((64'd1 << tal_pkg::SAMPLE_W) - 64'd1);
    localparam int          SUM_W   = $clog2(SUM_MAX + 64'd1);
    localparam logic [63:0] DEN     = 64'(SAMPLES) * ((64'd1 << tal_pkg::SAMPLE_W) - 64'd1)
                                      * 64'd256;
    localparam int          DIV_W   = $clog2(DEN + 64'd1);
    localparam int          NUM_W   = SUM_W + K_W;
    localparam int          CNT_W   = $clog2(SAMPLES + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_DIV_MV  = 3'd2;
    localparam logic [2:0] ST_SEG     = 3'd3;
    localparam logic [2:0] ST_DIV_NTU = 3'd4;
    localparam logic [2:0] ST_FINISH  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [tal_pkg::SCALE_W-1:0]    scale_reg, scale_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [MV_W-1:0]                mv_reg, mv_next;
    logic [NTU_W-1:0]               base_reg, base_next;
    logic [NTU_W-1:0]               tenths_reg, tenths_next;
    logic                           res_valid_reg, res_valid_next;
    logic [NTU_W-1:0]               res_tenths_reg, res_tenths_next;
    logic [tal_pkg::CLASS_W-1:0]    res_class_reg, res_class_next;
    logic [MV_W-1:0]                res_mv_reg, res_mv_next;

    logic                           sample_xfer;
    logic [SUM_W-1:0]               sum_new;
    logic                           mul_start;
    logic [K_W-1:0]                 mul_k;
    logic                           mul_done;
    logic [NUM_W-1:0]               mul_product;
    logic                           div_start;
    logic [NUM_W-1:0]               div_num;
    logic [DIV_W-1:0]               div_den;
    logic                           div_done;
    logic [MV_W-1:0]                div_quo;
    logic                           div_ovf;

    logic [CAL_W-1:0]               seg_hi;
    logic [CAL_W-1:0]               seg_lo;
    logic [NTU_W-1:0]               seg_base;
    logic [DN_W-1:0]                seg_dn;
    logic [OFF_W-1:0]               seg_off;
    logic [PROD_W-1:0]              seg_prod;
    logic                           seg_found;

    // Samples are taken only while the sequencer waits for the next group. A finished result
    // waiting in the output register does not hold off new samples.
    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_xfer  = sample.valid && sample.ready;
    assign sum_new      = sum_reg + SUM_W'(sample.adc_sample);

    // The scale times the reference voltage is the multiplicand of the serial multiplier.
    assign mul_k     = K_W'(scale_reg) * K_W'(tal_pkg::VREF_MV);
    assign mul_start = sample_xfer && (count_reg == CNT_W'(SAMPLES - 1));

    // Segment search: the first segment whose lower point is at or below the voltage. A
    // voltage that lands exactly on a table point therefore uses the segment above it.
    always_comb
    begin
        seg_found = 1'b0;
        seg_hi    = tal_pkg::CAL_MV[0];
        seg_lo    = tal_pkg::CAL_MV[1];
        seg_base  = tal_pkg::CAL_TENTHS[0];
        seg_dn    = DN_W'(tal_pkg::CAL_TENTHS[1] - tal_pkg::CAL_TENTHS[0]);
        for (int i = 0; i < tal_pkg::TABLE_POINTS - 1; i++)
        begin
            if (!seg_found && (mv_reg >= MV_W'(tal_pkg::CAL_MV[i + 1])))
            begin
                seg_found = 1'b1;
                seg_hi    = tal_pkg::CAL_MV[i];
                seg_lo    = tal_pkg::CAL_MV[i + 1];
                seg_base  = tal_pkg::CAL_TENTHS[i];
                seg_dn    = DN_W'(tal_pkg::CAL_TENTHS[i + 1] - tal_pkg::CAL_TENTHS[i]);
            end
        end
        // The offset into a segment never exceeds its span of at most 1000 mV.
        seg_off  = OFF_W'(MV_W'(seg_hi) - mv_reg);
        seg_prod = PROD_W'(seg_off) * PROD_W'(seg_dn);
    end

    // The divider is shared: first the millivolt conversion, then the interpolation step.
    always_comb
    begin
        if (state_reg == ST_MUL)
        begin
            div_num = mul_product;
            div_den = DIV_W'(DEN);
        end
        else
        begin
            div_num = NUM_W'(seg_prod);
            div_den = DIV_W'(seg_hi - seg_lo);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        scale_next      = scale_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        mv_next         = mv_reg;
        base_next       = base_reg;
        tenths_next     = tenths_reg;
        res_valid_next  = res_valid_reg;
        res_tenths_next = res_tenths_reg;
        res_class_next  = res_class_reg;
        res_mv_next     = res_mv_reg;
        div_start       = 1'b0;

        if (cfg_write_en)
        begin
            scale_next = cfg_write_data;
        end

        // The pending result leaves on its transfer; a new one may be loaded below.
        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    if (mul_start)
                    begin
                        // The closing sample hands the full sum to the multiplier.
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        sum_next   = sum_new;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_MV;
                end
            end
            ST_DIV_MV:
            begin
                if (div_done)
                begin
                    // Any quotient bit above 16 bits saturates the voltage.
                    mv_next    = div_ovf ? '1 : div_quo;
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (mv_reg >= MV_W'(tal_pkg::CAL_MV[0]))
                begin
                    // Clear water: at or above the top table point.
                    tenths_next = tal_pkg::TENTHS_CLEAR;
                    state_next  = ST_FINISH;
                end
                else if (mv_reg == '0)
                begin
                    // Zero voltage reads as the top of the scale.
                    tenths_next = tal_pkg::TENTHS_MAX;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    base_next  = seg_base;
                    div_start  = 1'b1;
                    state_next = ST_DIV_NTU;
                end
            end
            ST_DIV_NTU:
            begin
                if (div_done)
                begin
                    tenths_next = base_reg + div_quo;
                    state_next  = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // Wait until the output register is free or being emptied this cycle.
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next  = 1'b1;
                    res_tenths_next = tenths_reg;
                    res_class_next  = tal_pkg::classify(tenths_reg);
                    res_mv_next     = mv_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= tal_pkg::SCALE_RESET;
            sum_reg       <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_reg         <= mv_next;
        base_reg       <= base_next;
        tenths_reg     <= tenths_next;
        res_tenths_reg <= res_tenths_next;
        res_class_reg  <= res_class_next;
        res_mv_reg     <= res_mv_next;
    end

    tal_serial_mul #(
        .A_W (SUM_W),
        .B_W (K_W),
        .P_W (NUM_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sum_new),
        .b       (mul_k),
        .done    (mul_done),
        .product (mul_product)
    );

    tal_serial_div #(
        .N_W (NUM_W),
        .D_W (DIV_W),
        .Q_W (MV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo),
        .overflow (div_ovf)
    );

    assign result.valid         = res_valid_reg;
    assign result.ntu_tenths    = res_tenths_reg;
    assign result.quality_class = res_class_reg;
    assign result.sensor_mv     = res_mv_reg;

`ifndef SYNTHESIS
    // The multiplier finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its state");

    // The divider finishes only in one of the two division states.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIV_MV) || (state_reg == ST_DIV_NTU)))
        else $error("divider finished outside a division state");

    // The sample count stays below the group size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SAMPLES - 1))
        else $error("sample count beyond group size");

    // The closing sample of a group clears the sum and starts the conversion.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |=> ((state_reg == ST_MUL) && (sum_reg == '0) && (count_reg == '0)))
        else $error("group close did not clear the accumulator");

    // A presented result is in range and its class matches its turbidity.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.ntu_tenths <= tal_pkg::TENTHS_MAX) &&
                          (result.quality_class == tal_pkg::classify(result.ntu_tenths))))
        else $error("result out of range or misclassified");
`endif

endmodule

`default_nettype wire

/* tb/turbidity_average_linearize_unit_tb.sv */
// Self-checking testbench for the turbidity averaging and linearization unit.
module turbidity_average_linearize_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Field widths of the block.
    localparam int SAMPLE_W = tal_pkg::SAMPLE_W;
    localparam int SCALE_W  = tal_pkg::SCALE_W;
    localparam int NTU_W    = tal_pkg::NTU_W;
    localparam int CLASS_W  = tal_pkg::CLASS_W;
    localparam int MV_W     = tal_pkg::MV_W;

    // The block is built at its default group size.
    localparam int SAMPLES  = 10;
    localparam int ADC_BITS = SAMPLE_W;
    localparam int ADC_TOP  = (1 << ADC_BITS) - 1;

    // The divisor of the millivolt conversion: group size, converter full scale and the
    // 8 fraction bits of the scale factor.
    localparam longint unsigned MV_DIVISOR = longint'(SAMPLES) * ADC_TOP * 256;
    localparam int unsigned     MV_CEILING = 65535;

    // Calibration knees in mV and whole NTU, from clear water down to zero volts.
    localparam int unsigned KNEE_MV  [8] = '{4100, 3800, 3500, 3000, 2500, 2000, 1000, 0};
    localparam int unsigned KNEE_NTU [8] = '{0, 200, 500, 1000, 2000, 3000, 3800, 4000};

    // This pause lets the block work out the result of a group that the last sample closed.
    localparam int SETTLE_CYCLES = 128;
    localparam int RANDOM_ITEMS  = 1700;

    typedef struct packed {
        logic [NTU_W-1:0]   ntu;
        logic [CLASS_W-1:0] cls;
        logic [MV_W-1:0]    mv;
    } reading_t;

    // One directed group: the scale to run it at, the sum its samples must add up to,
    // and, where it can be read off at once, the reading that it must give.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [15:0]        group_sum;
        logic               typed;
        reading_t           want;
    } probe_row_t;

    localparam probe_row_t PROBE_TABLE [11] = '{
        // Straight out of reset: zero volts reads as the top of the table.
        '{tal_pkg::SCALE_RESET, 16'd0, 1'b1,
          '{tal_pkg::TENTHS_MAX, tal_pkg::CLASS_EXTREME, 16'd0}},
        // Full-scale samples at unity scale land inside the 3500..3000 mV segment.
        '{tal_pkg::SCALE_RESET, 16'd40950, 1'b1,
          '{16'd7000, tal_pkg::CLASS_FAIR, 16'd3300}},
        // Averages that land exactly on the 3000, 2000 and 1000 mV knees.
        '{tal_pkg::SCALE_RESET, 16'd37228, 1'b0, '0},
        '{tal_pkg::SCALE_RESET, 16'd24819, 1'b0, '0},
        '{tal_pkg::SCALE_RESET, 16'd12410, 1'b0, '0},
        // One millivolt, just above the zero-volt case.
        '{tal_pkg::SCALE_RESET, 16'd13,    1'b0, '0},
        // Exactly 4100 mV hits the clear-water clamp; one count lower does not.
        '{12'd319, 16'd40830, 1'b1,
          '{tal_pkg::TENTHS_CLEAR, tal_pkg::CLASS_EXCELLENT, 16'd4100}},
        '{12'd319, 16'd40829, 1'b0, '0},
        // Exactly on the 3800 mV knee.
        '{12'd319, 16'd37842, 1'b0, '0},
        // Largest scale with full-scale samples, then a zero scale.
        '{12'hFFF, 16'd40950, 1'b1,
          '{tal_pkg::TENTHS_CLEAR, tal_pkg::CLASS_EXCELLENT, 16'd52787}},
        '{12'h000, 16'd40950, 1'b1,
          '{tal_pkg::TENTHS_MAX, tal_pkg::CLASS_EXTREME, 16'd0}}
    };

    // Scales that the first random phases sweep through before they turn random.
    localparam logic [SCALE_W-1:0] SWEEP_SCALES [6] = '{
        12'hFFF, 12'h000, 12'd256, 12'd319, 12'd1, 12'd2048
    };

    // How the samples of one random group are drawn.
    typedef enum logic [1:0] {SPREAD_CLUSTER, SPREAD_UNIFORM, SPREAD_RAIL} spread_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en;
    logic [SCALE_W-1:0] cfg_write_data;

    tal_sample_if smp();
    tal_result_if res();

    turbidity_average_linearize_unit #(
        .SAMPLES  (SAMPLES)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .sample         (smp),
        .result         (res)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the block's state: the running group sum and count, and the scale
    // factor as last written.
    int unsigned        run_sum = 0;
    int unsigned        run_count = 0;
    logic [SCALE_W-1:0] scale_now = tal_pkg::SCALE_RESET;

    // Readings that the block still owes, oldest first.
    reading_t           expected_readings[$];

    // A directed group with a typed-in reading replaces the computed one with it.
    logic               probe_armed = 1'b0;
    reading_t           probe_want;

    // Both sides idle at random unless a stretch without idling is running.
    logic               idle_on = 1'b1;

    int unsigned        mismatch_count = 0;
    int unsigned        readings_checked = 0;
    int unsigned        samples_sent = 0;
    int unsigned        scale_loads = 0;
    int unsigned        clear_clamps = 0;
    int unsigned        class_hits [6] = '{0, 0, 0, 0, 0, 0};

    // Average of a group in millivolts, with the divider correction applied, truncated
    // and held at the top of the field.
    function automatic int unsigned average_millivolts(input int unsigned sum,
                                                       input int unsigned scale);
        longint unsigned num;
        longint unsigned mv;
        num = sum;
        num = num * tal_pkg::VREF_MV * scale;
        mv  = num / MV_DIVISOR;
        return (mv > MV_CEILING) ? MV_CEILING : int'(mv);
    endfunction

    // Linear interpolation through the knee table, in tenths of NTU. A voltage on a
    // knee takes the segment above it, which gives that knee's value exactly.
    function automatic int unsigned interpolate_tenths(input int unsigned mv);
        if (mv >= KNEE_MV[0])
            return KNEE_NTU[0] * 10;
        if (mv == 0)
            return KNEE_NTU[7] * 10;
        for (int i = 0; i < 7; i++)
        begin
            if (mv <= KNEE_MV[i] && mv >= KNEE_MV[i + 1])
                return KNEE_NTU[i] * 10
                     + ((KNEE_MV[i] - mv) * (KNEE_NTU[i + 1] - KNEE_NTU[i]) * 10)
                       / (KNEE_MV[i] - KNEE_MV[i + 1]);
        end
        return 0;
    endfunction

    function automatic logic [CLASS_W-1:0] grade_tenths(input int unsigned tenths);
        if (tenths < 500)
            return tal_pkg::CLASS_EXCELLENT;
        if (tenths < 2000)
            return tal_pkg::CLASS_GOOD;
        if (tenths < 10000)
            return tal_pkg::CLASS_FAIR;
        if (tenths < 25000)
            return tal_pkg::CLASS_POOR;
        if (tenths < 35000)
            return tal_pkg::CLASS_VERY_POOR;
        return tal_pkg::CLASS_EXTREME;
    endfunction

    // Adds one transferred sample to the shadow sum. The sample that closes a group
    // queues the reading it must produce and starts a fresh group.
    function automatic void absorb_sample(input logic [SAMPLE_W-1:0] adc);
        int unsigned mv;
        int unsigned tenths;
        reading_t    r;
        run_sum   += adc;
        run_count += 1;
        if (run_count == SAMPLES)
        begin
            mv     = average_millivolts(run_sum, scale_now);
            tenths = interpolate_tenths(mv);
            r.ntu  = tenths[NTU_W-1:0];
            r.cls  = grade_tenths(tenths);
            r.mv   = mv[MV_W-1:0];
            if (probe_armed)
            begin
                r           = probe_want;
                probe_armed = 1'b0;
            end
            expected_readings.push_back(r);
            run_sum   = 0;
            run_count = 0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    // Both monitors look at the values that stood just before the clock edge, so a
    // transfer is seen at the very edge that makes it.
    always @(posedge clk)
    begin
        if (rst_n && smp.valid && smp.ready)
            absorb_sample(smp.adc_sample);
    end

    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_readings.size() == 0)
            begin
                note_mismatch($sformatf("unexpected reading ntu=%0d class=%0d mv=%0d",
                                        res.ntu_tenths, res.quality_class, res.sensor_mv));
            end
            else
            begin
                want = expected_readings.pop_front();
                readings_checked++;
                if (want.cls <= tal_pkg::CLASS_EXTREME)
                    class_hits[want.cls]++;
                if (want.ntu == tal_pkg::TENTHS_CLEAR)
                    clear_clamps++;
                if (res.ntu_tenths !== want.ntu || res.quality_class !== want.cls
                    || res.sensor_mv !== want.mv)
                begin
                    note_mismatch($sformatf(
                        {"reading %0d: expected ntu=%0d class=%0d mv=%0d, ",
                         "got ntu=%0d class=%0d mv=%0d"},
                        readings_checked, want.ntu, want.cls, want.mv,
                        res.ntu_tenths, res.quality_class, res.sensor_mv));
                end
            end
        end
    end

    // While idling is on, the result side stalls at random, with a chance of one in five.
    always @(posedge clk)
    begin
        res.ready <= idle_on ? ($urandom_range(0, 99) >= 20) : 1'b1;
    end

    // Offers one sample after an optional random gap and returns at the edge that
    // takes it. Valid stays high afterwards so that back-to-back transfers are possible.
    task automatic send_sample(input logic [SAMPLE_W-1:0] adc);
        while (idle_on && $urandom_range(0, 99) < 20)
        begin
            smp.valid <= 1'b0;
            @(posedge clk);
        end
        smp.valid      <= 1'b1;
        smp.adc_sample <= adc;
        @(negedge clk);
        while (!smp.ready)
            @(negedge clk);
        @(posedge clk);
        samples_sent++;
    endtask

    // Stops offering samples, lets the block finish the group that the last sample may
    // have closed, then waits for every owed reading.
    task automatic settle();
        smp.valid <= 1'b0;
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // Writes the correction factor. Nothing is offered on the sample side meanwhile, so
    // the shadow copy can follow at once.
    task automatic load_scale(input logic [SCALE_W-1:0] scale);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= scale;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        scale_now     = scale;
        scale_loads++;
    endtask

    initial
    begin
        probe_row_t         row;
        int unsigned        part;
        int unsigned        random_sent;
        int unsigned        phase;
        int unsigned        span;
        int unsigned        fill;
        int unsigned        level;
        int                 pick;
        int                 t;
        logic [SCALE_W-1:0] scale;
        spread_e            spread;

        smp.valid      = 1'b0;
        smp.adc_sample = '0;
        res.ready      = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        spread         = SPREAD_CLUSTER;
        level          = 0;
        fill           = 0;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed groups. Each one is spread over its samples as evenly as possible;
        // the first scale change comes only after the reset value has been exercised.
        foreach (PROBE_TABLE[n])
        begin
            row = PROBE_TABLE[n];
            if (row.scale != scale_now)
            begin
                settle();
                load_scale(row.scale);
            end
            for (int k = 0; k < SAMPLES; k++)
            begin
                part = row.group_sum / SAMPLES + ((k < row.group_sum % SAMPLES) ? 1 : 0);
                send_sample(part[SAMPLE_W-1:0]);
                // Armed only once the group is under way, so that the reading of the
                // group before cannot pick it up.
                if (k == 0 && row.typed)
                begin
                    probe_want  = row.want;
                    probe_armed = 1'b1;
                end
            end
        end

        // Random phases, each at its own scale. Phase boundaries fall anywhere within a
        // group, so a scale change can also land in the middle of one. Phase 3 is a
        // long stretch in which neither side idles.
        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            if (phase < 6)
                scale = SWEEP_SCALES[phase];
            else if ($urandom_range(0, 1) == 1)
                scale = SCALE_W'($urandom_range(0, ADC_TOP));
            else
                scale = SCALE_W'($urandom_range(200, 400));
            load_scale(scale);
            idle_on = (phase != 3);
            span    = (phase == 3) ? 300 : $urandom_range(20, 240);
            repeat (span)
            begin
                // Most groups hover around one level so that their averages sweep the
                // whole table; the rest are noise or sit on the rails.
                if (fill == 0)
                begin
                    pick   = $urandom_range(0, 9);
                    spread = (pick < 5) ? SPREAD_CLUSTER
                           : (pick < 8) ? SPREAD_UNIFORM : SPREAD_RAIL;
                    level  = $urandom_range(0, ADC_TOP);
                end
                case (spread)
                    SPREAD_CLUSTER:
                    begin
                        t = int'(level) + int'($urandom_range(0, 32)) - 16;
                        t = (t < 0) ? 0 : (t > ADC_TOP) ? ADC_TOP : t;
                    end
                    SPREAD_UNIFORM:
                        t = $urandom_range(0, ADC_TOP);
                    default:
                        t = ($urandom_range(0, 3) == 0) ? 0 : ADC_TOP;
                endcase
                send_sample(t[SAMPLE_W-1:0]);
                fill = (fill == SAMPLES - 1) ? 0 : fill + 1;
                random_sent++;
            end
            phase++;
        end
        idle_on = 1'b1;

        settle();

        $display("Run covered %0d samples in %0d checked readings across %0d scale loads.",
                 samples_sent, readings_checked, scale_loads);
        $display("Readings by class: %0d/%0d/%0d/%0d/%0d/%0d (excellent..extreme), %0d %s",
                 class_hits[0], class_hits[1], class_hits[2], class_hits[3],
                 class_hits[4], class_hits[5], clear_clamps, "clamped clear.");
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // A correct run takes well under half a millisecond of simulated time.
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d readings still owed.", expected_readings.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* turbidity_average_linearize_unit.f */
src/tal_pkg.sv
src/tal_sample_if.sv
src/tal_result_if.sv
src/tal_serial_mul.sv
src/tal_serial_div.sv
src/turbidity_average_linearize_unit.sv
tb/turbidity_average_linearize_unit_tb.sv
